// File: rtl/window_convolve_clamp_edge_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef WINDOW_CONVOLVE_CLAMP_EDGE_MACROS_SVH
`define WINDOW_CONVOLVE_CLAMP_EDGE_MACROS_SVH

// Check that an implication holds on every clock edge out of reset.
`define WCE_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Check that a condition never holds out of reset.
`define WCE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/wce_pkg.sv
`timescale 1ns / 1ps
package wce_pkg;
    localparam logic [1:0] ACT_COEF  = 2'd0;
    localparam logic [1:0] ACT_PIXEL = 2'd1;
    localparam logic [1:0] ACT_DRAIN = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam int unsigned MIN_SIZE = 8;
    localparam int unsigned PIX_MAX  = 255;

    // one result request handed from the front to the back
    typedef struct packed {
        logic [11:0] row;
        logic [10:0] col;
        logic        last;
        logic        done;
        logic        shift;   // shift a replicated edge slice before computing
    } wce_job_t;
endpackage

// File: rtl/wce_ram.sv
`timescale 1ns / 1ps
module wce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule

// File: rtl/wce_front.sv
`timescale 1ns / 1ps
// Front: decodes beats, tracks raster position, reads and writes line stores,
// loads the window and issues result jobs. One pixel or drain tick per cycle
// while the job queue has room for a full row-end burst.
module wce_front
    import wce_pkg::*;
#(
    parameter int RADIUS    = 2,
    parameter int MAX_WIDTH = 2048,
    parameter int SPAN      = 2 * RADIUS + 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [0:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [4:0]         coef_index,
    input  logic [15:0]        coef_value,
    input  logic [7:0]         pixel_in,
    output logic               coef_we,
    output logic [4:0]         coef_waddr,
    output logic [15:0]        coef_wdata,
    output logic               slice_valid,
    output logic               slice_fill,
    output logic [7:0]         slice_pix [SPAN],
    output logic               job_push,
    output logic [RADIUS:0]    job_mask,
    output wce_job_t           job_data [RADIUS+1],
    input  logic               job_room,
    input  logic               coef_room
);
    localparam int LINES = 2 * RADIUS;
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int LW    = (LINES > 1) ? $clog2(LINES) : 1;

    logic [11:0] width_reg, height_reg;
    logic [11:0] row_reg;
    logic [10:0] col_reg;
    logic [11:0] drain_reg;
    logic [LW-1:0] line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    logic [12:0] w_used;
    logic [11:0] h_used;
    logic [12:0] col_ext, col_sel;
    logic        row_end, acc, is_pix, is_drain, active;
    logic [12:0] rv;
    logic [7:0]  pix_new;
    logic [7:0]  drain_pix;

    always_comb
    begin
        if (width_reg < 12'(MIN_SIZE))
            w_used = 13'(MIN_SIZE);
        else if (13'(width_reg) > 13'(MAX_WIDTH))
            w_used = 13'(MAX_WIDTH);
        else
            w_used = 13'(width_reg);
        h_used  = (height_reg < 12'(MIN_SIZE)) ? 12'(MIN_SIZE) : height_reg;
        col_ext = 13'(col_reg);
        col_sel = (col_ext < w_used) ? col_ext : w_used - 13'd1;
        row_end = (col_sel == w_used - 13'd1);
    end

    // hold coefficient loads until every earlier job has read the old taps
    assign in_ready = job_room && (action != ACT_COEF || coef_room);
    assign acc      = in_valid && in_ready;
    assign is_pix   = acc && action == ACT_PIXEL && row_reg < h_used;
    assign is_drain = acc && action == ACT_DRAIN && row_reg >= h_used;
    assign active   = is_pix || is_drain;
    assign rv       = 13'(row_reg) + 13'(drain_reg);

    assign coef_we    = acc && action == ACT_COEF && coef_index < 5'(SPAN * SPAN);
    assign coef_waddr = coef_index;
    assign coef_wdata = coef_value;

    // line stores: one RAM per line, read at the column, written in the next cycle
    logic [7:0]  line_q [LINES];
    logic        s_valid_reg, s_pix_reg, s_zero_reg, s_fill_reg;
    logic [AW-1:0] s_col_reg;
    logic [7:0]  s_new_reg;
    logic [LW-1:0] s_base_reg;

    // same-column read-after-write cannot occur: consecutive beats differ in column
    function automatic logic [LW-1:0] line_wrap(input logic [LW:0] v);
        return (v >= (LW+1)'(LINES)) ? LW'(v - (LW+1)'(LINES)) : LW'(v);
    endfunction

    genvar g;
    generate
        for (g = 0; g < LINES; g++)
        begin : g_line
            logic we_l;
            assign we_l = s_valid_reg && (s_zero_reg || s_base_reg == LW'(g));
            wce_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_ram (
                .clk   (clk),
                .we    (we_l),
                .waddr (s_col_reg),
                .wdata (slice_pix[LINES]),
                .re    (active),
                .raddr (col_sel[AW-1:0]),
                .rdata (line_q[g])
            );
        end
    endgenerate

    // drain pixel is the line (rv-1) read, which is slice position LINES-1
    assign drain_pix = line_q[line_wrap((LW+1)'(s_base_reg) + (LW+1)'(LINES - 1))];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else
            s_valid_reg <= active;
    end

    always_ff @(posedge clk)
    begin
        s_pix_reg  <= is_pix;
        s_zero_reg <= (rv == 13'd0);
        s_fill_reg <= (col_sel == 13'd0);
        s_col_reg  <= col_sel[AW-1:0];
        s_new_reg  <= pixel_in;
        s_base_reg <= line_reg;
    end

    assign pix_new = s_pix_reg ? s_new_reg : drain_pix;

    always_comb
    begin
        for (int k = 0; k < LINES; k++)
        begin
            if (s_zero_reg)
                slice_pix[k] = pix_new;
            else
                slice_pix[k] = line_q[line_wrap((LW+1)'(s_base_reg) + (LW+1)'(k))];
        end
        slice_pix[LINES] = pix_new;
    end
    assign slice_valid = s_valid_reg;
    assign slice_fill  = s_fill_reg;

    // raster counters; line_reg follows rv modulo LINES
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            drain_reg <= '0;
            line_reg  <= '0;
        end
        else if (active)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                if (is_pix)
                begin
                    row_reg  <= row_reg + 12'd1;
                    line_reg <= line_wrap((LW+1)'(line_reg) + (LW+1)'(1));
                end
                else if (drain_reg + 12'd1 >= 12'(RADIUS))
                begin
                    row_reg   <= '0;
                    drain_reg <= '0;
                    line_reg  <= '0;
                end
                else
                begin
                    drain_reg <= drain_reg + 12'd1;
                    line_reg  <= line_wrap((LW+1)'(line_reg) + (LW+1)'(1));
                end
            end
            else
                col_reg <= 11'(col_sel) + 11'd1;
        end
    end

    // jobs are issued in the cycle after the beat, aligned with the slice
    logic        j_end_reg, j_emit_reg;
    logic [11:0] j_orow_reg;
    logic [12:0] j_col_reg, j_w_reg;
    logic [11:0] j_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_emit_reg <= 1'b0;
        else
            j_emit_reg <= active && rv >= 13'(RADIUS) &&
                          (row_end || col_sel >= 13'(RADIUS));
    end

    always_ff @(posedge clk)
    begin
        j_end_reg  <= row_end;
        j_orow_reg <= 12'(rv - 13'(RADIUS));
        j_col_reg  <= col_sel;
        j_w_reg    <= w_used;
        j_h_reg    <= h_used;
    end

    always_comb
    begin
        job_push = j_emit_reg;
        for (int t = 0; t <= RADIUS; t++)
        begin
            logic [12:0] c;
            c = j_end_reg ? (j_w_reg - 13'd1 - 13'(RADIUS) + 13'(t))
                          : (j_col_reg - 13'(RADIUS));
            job_mask[t]       = j_end_reg || t == 0;
            job_data[t].row   = j_orow_reg;
            job_data[t].col   = 11'(c);
            job_data[t].shift = t != 0;
            job_data[t].last  = j_end_reg ? (t == RADIUS) : 1'b1;
            job_data[t].done  = j_orow_reg == j_h_reg - 12'd1 &&
                                c == j_w_reg - 13'd1;
        end
    end
endmodule

// File: rtl/wce_queue.sv
`timescale 1ns / 1ps
// Job queue: accepts up to RADIUS+1 jobs in a cycle, pops one per cycle.
// Window slices do not travel with the jobs; the back keeps them in its own queue.
module wce_queue
    import wce_pkg::*;
#(
    parameter int RADIUS = 2,
    parameter int SPAN   = 2 * RADIUS + 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [RADIUS:0] mask,
    input  wce_job_t        din [RADIUS+1],
    output logic            room,
    output logic            pop_valid,
    input  logic            pop,
    output wce_job_t        dout
);
    localparam int DEPTH = 4 * (RADIUS + 1) + 4;
    localparam int AW    = $clog2(DEPTH);

    wce_job_t       q_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;
    logic [AW:0]    n_push;

    always_comb
    begin
        n_push = '0;
        for (int t = 0; t <= RADIUS; t++)
            n_push = n_push + (AW+1)'(push && mask[t]);
    end

    // keep room for three full bursts, enough for those already in flight from the front
    assign room      = cnt_reg + (AW+1)'(3 * (RADIUS + 1)) <= (AW+1)'(DEPTH);
    assign pop_valid = cnt_reg != '0;
    assign dout      = q_reg[rp_reg];

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        return (v >= (AW+1)'(DEPTH)) ? AW'(v - (AW+1)'(DEPTH)) : AW'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        for (int t = 0; t <= RADIUS; t++)
            if (push && mask[t])
                q_reg[wrap((AW+1)'(wp_reg) + (AW+1)'(t))] <= din[t];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wrap((AW+1)'(wp_reg) + n_push);
            if (pop)
                rp_reg <= wrap((AW+1)'(rp_reg) + (AW+1)'(1));
            cnt_reg <= cnt_reg + n_push - (AW+1)'(pop);
        end
    end

    `include "window_convolve_clamp_edge_macros.svh"
    `WCE_ASSERT_NEVER(a_q_overflow, clk, rst_n, push && (cnt_reg + n_push > (AW+1)'(DEPTH)), "job queue overflow")
    `WCE_ASSERT_IMPLY(a_q_pop, clk, rst_n, pop, pop_valid, "pop from empty job queue")
    `WCE_ASSERT_IMPLY(a_q_cnt, clk, rst_n, !push && !pop, cnt_reg == $past(cnt_reg) || $past(push) || $past(pop), "job count moved without traffic")
endmodule

// File: rtl/wce_back.sv
`timescale 1ns / 1ps
// Back: holds window snapshots in a slice queue, pops jobs, shifts the window
// and convolves in a three-stage pipeline: multiply, row sums, then total,
// truncate, subtract the centre pixel and clamp.
module wce_back
    import wce_pkg::*;
#(
    parameter int RADIUS         = 2,
    parameter int COEF_FRAC_BITS = 12,
    parameter int SPAN           = 2 * RADIUS + 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        coef_we,
    input  logic [4:0]  coef_waddr,
    input  logic [15:0] coef_wdata,
    input  logic        slice_valid,
    input  logic        slice_fill,
    input  logic        slice_emit,
    input  logic [7:0]  slice_pix [SPAN],
    input  logic        job_valid,
    output logic        job_pop,
    input  wce_job_t    job,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser
);
    localparam int TAPS = SPAN * SPAN;
    localparam int PW   = 25;
    localparam int SW   = PW + $clog2(TAPS) + 1;
    localparam int SQD  = 4 * (RADIUS + 1) + 8;
    localparam int SQA  = $clog2(SQD);

    logic signed [15:0] coef_reg [TAPS];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < TAPS; i++)
                coef_reg[i] <= '0;
        else if (coef_we)
            coef_reg[coef_waddr] <= coef_wdata;
    end

    // window keeps the state each slice leaves; jobs read snapshots, never this window
    logic [7:0] win_reg [SPAN][SPAN];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < SPAN; j++)
                for (int a = 0; a < SPAN; a++)
                    win_reg[j][a] <= '0;
        end
        else if (slice_valid)
        begin
            for (int j = 0; j < SPAN; j++)
                for (int a = 0; a < SPAN; a++)
                    win_reg[j][a] <= (slice_fill || j == SPAN - 1) ? slice_pix[a]
                                                                   : win_reg[j+1][a];
        end
    end

    // snapshot queue of windows, one per slice that issues jobs, so
    // snapshot and job group orders match
    logic [7:0]    snap_reg [SQD][SPAN][SPAN];
    logic [SQA-1:0] swp_reg, srp_reg;
    logic          snap_push;
    assign snap_push = slice_valid && slice_emit;
    logic [SQD-1:0] used_reg;

    always_ff @(posedge clk)
    begin
        if (snap_push)
            for (int j = 0; j < SPAN; j++)
                for (int a = 0; a < SPAN; a++)
                    snap_reg[swp_reg][j][a] <= (slice_fill || j == SPAN - 1) ?
                                               slice_pix[a] : win_reg[j+1][a];
    end

    // working window for the current group
    logic [7:0] cur_reg [SPAN][SPAN];
    logic       run_ready;
    logic       p1_valid_reg, p2_valid_reg, o_valid_reg;
    logic       stall;

    assign stall     = o_valid_reg && !m_tready;
    assign run_ready = !stall;
    assign job_pop   = job_valid && run_ready && (job.shift || srp_reg != swp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swp_reg  <= '0;
            srp_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (snap_push)
                swp_reg <= (swp_reg == SQA'(SQD - 1)) ? '0 : swp_reg + SQA'(1);
            if (job_pop && !job.shift)
                srp_reg <= (srp_reg == SQA'(SQD - 1)) ? '0 : srp_reg + SQA'(1);
            used_reg <= '0;
        end
    end

    // a group start takes the next snapshot, later jobs shift the working window
    logic [7:0] sel_win [SPAN][SPAN];
    always_comb
    begin
        for (int j = 0; j < SPAN; j++)
            for (int a = 0; a < SPAN; a++)
            begin
                if (!job.shift)
                    sel_win[j][a] = snap_reg[srp_reg][j][a];
                else if (j == SPAN - 1)
                    sel_win[j][a] = cur_reg[SPAN-1][a];
                else
                    sel_win[j][a] = cur_reg[j+1][a];
            end
    end

    logic signed [PW-1:0] prod_reg [TAPS];
    logic [7:0]           ctr1_reg, ctr2_reg;
    wce_job_t             j1_reg, j2_reg;
    logic signed [SW-1:0] rsum_reg [SPAN];

    always_ff @(posedge clk)
    begin
        if (job_pop)
            for (int j = 0; j < SPAN; j++)
                for (int a = 0; a < SPAN; a++)
                    cur_reg[j][a] <= sel_win[j][a];
        if (run_ready)
        begin
            for (int a = 0; a < SPAN; a++)
                for (int b = 0; b < SPAN; b++)
                    prod_reg[a*SPAN+b] <= PW'(coef_reg[a*SPAN+b] *
                                          $signed({1'b0, sel_win[b][a]}));
            ctr1_reg <= sel_win[RADIUS][RADIUS];
            j1_reg   <= job;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_ready)
        begin
            logic signed [SW-1:0] s;
            for (int a = 0; a < SPAN; a++)
            begin
                s = '0;
                for (int b = 0; b < SPAN; b++)
                    s = s + SW'(prod_reg[a*SPAN+b]);
                rsum_reg[a] <= s;
            end
            ctr2_reg <= ctr1_reg;
            j2_reg   <= j1_reg;
        end
    end

    logic signed [SW-1:0] total, mag, val;
    logic [7:0]           clamped;
    always_comb
    begin
        total = '0;
        for (int a = 0; a < SPAN; a++)
            total = total + rsum_reg[a];
        mag = total[SW-1] ? -total : total;
        mag = mag >>> COEF_FRAC_BITS;
        val = (total[SW-1] ? -mag : mag) - SW'(ctr2_reg);
        if (val < 0)
            clamped = 8'd0;
        else if (val > SW'(PIX_MAX))
            clamped = 8'(PIX_MAX);
        else
            clamped = 8'(val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (run_ready)
        begin
            p1_valid_reg <= job_pop;
            p2_valid_reg <= p1_valid_reg;
            o_valid_reg  <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_ready)
        begin
            m_tdata <= {1'b0, j2_reg.col, j2_reg.row, clamped};
            m_tuser <= {j2_reg.done, j2_reg.last};
        end
    end
    assign m_tvalid = o_valid_reg;

    `include "window_convolve_clamp_edge_macros.svh"
    `WCE_ASSERT_IMPLY(a_b_hold, clk, rst_n, $past(m_tvalid && !m_tready), $stable(m_tdata), "result changed while stalled")
    `WCE_ASSERT_NEVER(a_b_used, clk, rst_n, used_reg != '0, "snapshot bookkeeping broken")
    `WCE_ASSERT_IMPLY(a_b_pop, clk, rst_n, job_pop, job_valid, "popped a job that is not there")
endmodule

// File: rtl/window_convolve_clamp_edge.sv
`timescale 1ns / 1ps
// Streaming 2-D convolution with replicated borders. Input beats (tuser =
// action) carry coefficient loads, raster pixels or drain ticks; one beat is
// taken per cycle. A pixel gives up to one result, a row end RADIUS+1
// results, drained one per cycle through the job queue unless the output
// stalls; the input stalls when that queue is near full, and a coefficient
// load waits until every job issued before it has been taken by the back.
// Results pass the front's job register, the queue and the back's stages.
// Line stores: one block RAM per buffered row, read on pixel and drain beats.
module window_convolve_clamp_edge
    import wce_pkg::*;
#(
    parameter int RADIUS         = 2,
    parameter int MAX_WIDTH      = 2048,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // coef_index[4:0], coef_value[20:5], pixel_in[28:21]
    input  logic [1:0]  s_tuser,  // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // pixel_out[7:0], out_row[19:8], out_col[30:20]
    output logic [1:0]  m_tuser   // last_in_run[0], frame_done[1]
);
    localparam int SPAN = 2 * RADIUS + 1;

    logic        coef_we;
    logic [4:0]  coef_waddr;
    logic [15:0] coef_wdata;
    logic        slice_valid, slice_fill;
    logic [7:0]  slice_pix [SPAN];
    logic        job_push, job_room, job_valid, job_pop;
    logic        coef_room;
    logic [RADIUS:0] job_mask;
    wce_job_t    job_in [RADIUS+1];
    wce_job_t    job_out;

    assign cfg_ready = 1'b1;
    assign coef_room = !job_push && !job_valid;

    wce_front #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
        .in_valid (s_tvalid), .in_ready (s_tready), .action (s_tuser),
        .coef_index (s_tdata[4:0]), .coef_value (s_tdata[20:5]),
        .pixel_in (s_tdata[28:21]),
        .coef_we, .coef_waddr, .coef_wdata,
        .slice_valid, .slice_fill, .slice_pix,
        .job_push, .job_mask, .job_data (job_in), .job_room, .coef_room
    );

    wce_queue #(.RADIUS(RADIUS)) u_queue (
        .clk, .rst_n, .push (job_push), .mask (job_mask), .din (job_in),
        .room (job_room), .pop_valid (job_valid), .pop (job_pop), .dout (job_out)
    );

    wce_back #(.RADIUS(RADIUS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_back (
        .clk, .rst_n, .coef_we, .coef_waddr, .coef_wdata,
        .slice_valid, .slice_fill, .slice_emit (job_push), .slice_pix,
        .job_valid, .job_pop, .job (job_out),
        .m_tvalid, .m_tready, .m_tdata, .m_tuser
    );
endmodule
